@@ design/pdr_pkg.sv @@
// Package for the point de-duplication block.
// Holds the transaction payload structs, the cell control struct and shared constants.
// No dependencies.
`timescale 1ns / 1ps

package pdr_pkg;

  localparam int unsigned FIELD_COORD_BITS = 12;
  localparam int unsigned FIELD_INDEX_BITS = 6;
  localparam int unsigned RADIUS_BITS      = 8;
  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 8'd5;

  localparam int unsigned DEF_TABLE_DEPTH = 64;
  localparam int unsigned DEF_COORD_BITS  = 12;

  typedef struct packed {
    logic [FIELD_COORD_BITS-1:0] x;
    logic [FIELD_COORD_BITS-1:0] y;
    logic                        first;
  } pdr_in_t;

  typedef struct packed {
    logic                        is_new;
    logic [FIELD_INDEX_BITS-1:0] cluster_index;
    logic [FIELD_COORD_BITS-1:0] rep_x;
    logic [FIELD_COORD_BITS-1:0] rep_y;
    logic                        overflow;
  } pdr_out_t;

  typedef struct packed {
    logic valid;
    logic epoch;
    logic done;
    logic is_new;
  } pdr_ctl_t;

endpackage

@@ design/point_dedup_by_radius_top.sv @@
// Top level of the point de-duplication block: radius register, set epoch and cell chain.
// Depends on pdr_pkg and pdr_cell.
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+---------------------------
//   input    | in        | start, busy                | in_i  (x, y, first)
//   result   | out       | out_valid_o strobe         | out_o (is_new, index, rep)
//   config   | in        | cfg_valid_i, cfg_ready_o   | cfg_data_i (match radius)
//
// A point can be started in every cycle; busy is never raised.
// Each result passes through the cells of the chain, one cell of the chain per cycle,
// and appears at its end in start order, for a single cycle.
// Reset clears the table and the chain; no clearing pass is needed.
// The receiver cannot stall, so nothing holds the chain back.
`timescale 1ns / 1ps

module point_dedup_by_radius_top
  import pdr_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned COORD_BITS  = DEF_COORD_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  pdr_in_t                in_i,
  output logic                   out_valid_o,
  output pdr_out_t               out_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [RADIUS_BITS-1:0] cfg_data_i
);

  localparam int unsigned IDX_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [RADIUS_BITS-1:0] radius_q;
  logic                   epoch_q;
  logic                   accept;
  logic                   tok_epoch;

  pdr_ctl_t              ctl  [TABLE_DEPTH+1];
  logic [COORD_BITS-1:0] px   [TABLE_DEPTH+1];
  logic [COORD_BITS-1:0] py   [TABLE_DEPTH+1];
  logic [COORD_BITS-1:0] prx  [TABLE_DEPTH+1];
  logic [COORD_BITS-1:0] pry  [TABLE_DEPTH+1];
  logic [IDX_BITS-1:0]   pidx [TABLE_DEPTH+1];

  pdr_ctl_t              last_ctl;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign tok_epoch   = in_i.first ? !epoch_q : epoch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
      epoch_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        radius_q <= cfg_data_i;
      end
      if (accept) begin
        epoch_q <= tok_epoch;
      end
    end
  end

  assign ctl[0]  = pdr_ctl_t'{valid: accept, epoch: tok_epoch, done: 1'b0, is_new: 1'b0};
  assign px[0]   = COORD_BITS'(in_i.x);
  assign py[0]   = COORD_BITS'(in_i.y);
  assign prx[0]  = '0;
  assign pry[0]  = '0;
  assign pidx[0] = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    pdr_cell #(
      .COORD_BITS(COORD_BITS),
      .IDX_BITS  (IDX_BITS),
      .CELL_IDX  (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .radius_i(radius_q),
      .ctl_i   (ctl[i]),
      .x_i     (px[i]),
      .y_i     (py[i]),
      .rx_i    (prx[i]),
      .ry_i    (pry[i]),
      .idx_i   (pidx[i]),
      .ctl_o   (ctl[i+1]),
      .x_o     (px[i+1]),
      .y_o     (py[i+1]),
      .rx_o    (prx[i+1]),
      .ry_o    (pry[i+1]),
      .idx_o   (pidx[i+1])
    );
  end

  assign last_ctl    = ctl[TABLE_DEPTH];
  assign out_valid_o = last_ctl.valid;

  always_comb begin
    out_o = '0;
    if (last_ctl.done) begin
      out_o.is_new        = last_ctl.is_new;
      out_o.cluster_index = FIELD_INDEX_BITS'(pidx[TABLE_DEPTH]);
      out_o.rep_x         = FIELD_COORD_BITS'(prx[TABLE_DEPTH]);
      out_o.rep_y         = FIELD_COORD_BITS'(pry[TABLE_DEPTH]);
    end else begin
      out_o.overflow      = 1'b1;
    end
  end

  a_result_follows_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##TABLE_DEPTH out_valid_o)
    else $error("Accepted transaction did not produce a result on time.");

  a_result_has_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(accept, TABLE_DEPTH))
    else $error("Result strobe without a matching accepted transaction.");

  a_first_point_is_new : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.first) |-> ##TABLE_DEPTH (out_o.is_new && out_o.cluster_index == '0))
    else $error("First point of a set did not become entry zero.");

  a_new_xor_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_o.is_new && out_o.overflow))
    else $error("Result flagged both new and overflow.");

endmodule

@@ design/pdr_cell.sv @@
// One cell of the representative chain: holds one table entry and one travelling point.
// Depends on pdr_pkg.
`timescale 1ns / 1ps

module pdr_cell
  import pdr_pkg::*;
#(
  parameter int unsigned COORD_BITS = DEF_COORD_BITS,
  parameter int unsigned IDX_BITS   = 6,
  parameter int unsigned CELL_IDX   = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [RADIUS_BITS-1:0] radius_i,
  input  pdr_ctl_t               ctl_i,
  input  logic [COORD_BITS-1:0]  x_i,
  input  logic [COORD_BITS-1:0]  y_i,
  input  logic [COORD_BITS-1:0]  rx_i,
  input  logic [COORD_BITS-1:0]  ry_i,
  input  logic [IDX_BITS-1:0]    idx_i,
  output pdr_ctl_t               ctl_o,
  output logic [COORD_BITS-1:0]  x_o,
  output logic [COORD_BITS-1:0]  y_o,
  output logic [COORD_BITS-1:0]  rx_o,
  output logic [COORD_BITS-1:0]  ry_o,
  output logic [IDX_BITS-1:0]    idx_o
);

  localparam int unsigned CMP_BITS = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;

  logic                  valid_q, valid_d;
  logic                  epoch_q, epoch_d;
  logic [COORD_BITS-1:0] col_q, col_d;
  logic [COORD_BITS-1:0] row_q, row_d;

  pdr_ctl_t              ctl_q, ctl_d;
  logic [COORD_BITS-1:0] x_q, y_q, rx_q, rx_d, ry_q, ry_d;
  logic [IDX_BITS-1:0]   idx_q, idx_d;

  logic [COORD_BITS:0]   diff_x, diff_y;
  logic [COORD_BITS-1:0] abs_x, abs_y;
  logic                  owned, match;

  assign diff_x = {1'b0, x_i} - {1'b0, col_q};
  assign diff_y = {1'b0, y_i} - {1'b0, row_q};
  assign abs_x  = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
  assign abs_y  = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];
  assign match  = (CMP_BITS'(abs_x) < CMP_BITS'(radius_i)) &&
                  (CMP_BITS'(abs_y) < CMP_BITS'(radius_i));
  assign owned  = valid_q && (epoch_q == ctl_i.epoch);

  always_comb begin
    ctl_d   = ctl_i;
    rx_d    = rx_i;
    ry_d    = ry_i;
    idx_d   = idx_i;
    valid_d = valid_q;
    epoch_d = epoch_q;
    col_d   = col_q;
    row_d   = row_q;
    if (ctl_i.valid) begin
      epoch_d = ctl_i.epoch;
      if (!owned) begin
        valid_d = 1'b0;
      end
      if (!ctl_i.done) begin
        if (owned && match) begin
          ctl_d.done   = 1'b1;
          ctl_d.is_new = 1'b0;
          idx_d        = IDX_BITS'(CELL_IDX);
          rx_d         = col_q;
          ry_d         = row_q;
        end else if (!owned) begin
          ctl_d.done   = 1'b1;
          ctl_d.is_new = 1'b1;
          idx_d        = IDX_BITS'(CELL_IDX);
          rx_d         = x_i;
          ry_d         = y_i;
          valid_d      = 1'b1;
          col_d        = x_i;
          row_d        = y_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      epoch_q <= 1'b0;
      ctl_q   <= '0;
    end else begin
      valid_q <= valid_d;
      epoch_q <= epoch_d;
      ctl_q   <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q <= col_d;
    row_q <= row_d;
    x_q   <= x_i;
    y_q   <= y_i;
    rx_q  <= rx_d;
    ry_q  <= ry_d;
    idx_q <= idx_d;
  end

  assign ctl_o = ctl_q;
  assign x_o   = x_q;
  assign y_o   = y_q;
  assign rx_o  = rx_q;
  assign ry_o  = ry_q;
  assign idx_o = idx_q;

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for point_dedup_by_radius_top: clustering of image points by radius.
// A scoreboard class predicts every result from its own copy of the cluster table; tasks drive it.
// Depends on pdr_pkg and point_dedup_by_radius_top.
`timescale 1ns / 1ps

module tb_top;
  import pdr_pkg::*;

  localparam int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH;
  localparam int          COORD_MAX   = (1 << FIELD_COORD_BITS) - 1;
  localparam int          MAX_REPORTS = 10;

  class cluster_scoreboard;
    logic [FIELD_COORD_BITS-1:0] rep_col[TABLE_DEPTH];
    logic [FIELD_COORD_BITS-1:0] rep_row[TABLE_DEPTH];
    int                          entry_count;
    logic [RADIUS_BITS-1:0]      radius;
    pdr_out_t                    expected_clusters[$];
    int                          errors;

    function new();
      entry_count = 0;
      radius      = RADIUS_RESET;
      errors      = 0;
    endfunction

    function void set_radius(logic [RADIUS_BITS-1:0] value);
      radius = value;
    endfunction

    function int distance(int a, int b);
      return (a >= b) ? a - b : b - a;
    endfunction

    function void note_point(pdr_in_t p);
      pdr_out_t cluster;
      int       k;
      bit       hit;
      cluster = '0;
      hit     = 1'b0;
      if (p.first) begin
        entry_count = 0;
      end
      for (k = 0; k < entry_count && !hit; k++) begin
        if (distance(int'(p.x), int'(rep_col[k])) < int'(radius) &&
            distance(int'(p.y), int'(rep_row[k])) < int'(radius)) begin
          hit                   = 1'b1;
          cluster.cluster_index = FIELD_INDEX_BITS'(k);
          cluster.rep_x         = rep_col[k];
          cluster.rep_y         = rep_row[k];
        end
      end
      if (!hit) begin
        if (entry_count < TABLE_DEPTH) begin
          rep_col[entry_count]  = p.x;
          rep_row[entry_count]  = p.y;
          cluster.is_new        = 1'b1;
          cluster.cluster_index = FIELD_INDEX_BITS'(entry_count);
          cluster.rep_x         = p.x;
          cluster.rep_y         = p.y;
          entry_count++;
        end else begin
          cluster.overflow = 1'b1;
        end
      end
      expected_clusters.insert(expected_clusters.size(), cluster);
    endfunction

    function void check_result(pdr_out_t got);
      pdr_out_t want;
      if (expected_clusters.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("unexpected result: is_new=%0d idx=%0d rep=(%0d,%0d) overflow=%0d",
                   got.is_new, got.cluster_index, got.rep_x, got.rep_y, got.overflow);
        end
        return;
      end
      want = expected_clusters.pop_front();
      if (got.is_new !== want.is_new || got.cluster_index !== want.cluster_index ||
          got.rep_x !== want.rep_x || got.rep_y !== want.rep_y ||
          got.overflow !== want.overflow) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("mismatch at %0t: expected is_new=%0d idx=%0d rep=(%0d,%0d) overflow=%0d",
                   $realtime, want.is_new, want.cluster_index, want.rep_x, want.rep_y,
                   want.overflow);
          $display("                 actual   is_new=%0d idx=%0d rep=(%0d,%0d) overflow=%0d",
                   got.is_new, got.cluster_index, got.rep_x, got.rep_y, got.overflow);
        end
      end
    endfunction

    function int pending();
      return expected_clusters.size();
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  pdr_in_t                in_i;
  logic                   out_valid_o;
  pdr_out_t               out_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [RADIUS_BITS-1:0] cfg_data_i;

  cluster_scoreboard sb = new();
  int                cur_radius = RADIUS_RESET;

  point_dedup_by_radius_top #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .COORD_BITS (DEF_COORD_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_o      (out_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o) begin
        sb.check_result(out_o);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        sb.set_radius(cfg_data_i);
      end
      if (start && !busy) begin
        sb.note_point(in_i);
      end
    end
  end

  task automatic send_point(input pdr_in_t p, input int gap);
    if (gap > 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start = 1'b1;
    in_i  = p;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    start = 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
  endtask

  task automatic write_radius(input int value);
    wait_drain();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = RADIUS_BITS'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cur_radius  = value;
  endtask

  task automatic send_xy(input int x, input int y, input bit first);
    pdr_in_t p;
    p.x     = FIELD_COORD_BITS'(x);
    p.y     = FIELD_COORD_BITS'(y);
    p.first = first;
    send_point(p, $urandom_range(0, 8));
  endtask

  function automatic int pick_coord();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return COORD_MAX;
      default: return $urandom_range(0, COORD_MAX);
    endcase
  endfunction

  function automatic int clamp_coord(input int c);
    if (c < 0) begin
      return 0;
    end
    if (c > COORD_MAX) begin
      return COORD_MAX;
    end
    return c;
  endfunction

  task automatic run_sets(input int n_items);
    int      sent;
    int      set_len;
    int      i;
    int      pick;
    int      bx;
    int      by;
    bit      burst;
    int      xs[$];
    int      ys[$];
    pdr_in_t p;
    sent = 0;
    while (sent < n_items) begin
      set_len = ($urandom_range(0, 3) == 0) ? $urandom_range(65, 100) : $urandom_range(1, 40);
      burst   = ($urandom_range(0, 3) == 0);
      xs.delete();
      ys.delete();
      for (i = 0; i < set_len && sent < n_items; i++) begin
        if (xs.size() > 0 && $urandom_range(0, 1) == 1) begin
          pick = $urandom_range(0, xs.size() - 1);
          bx   = clamp_coord(xs[pick] + $urandom_range(0, 2 * cur_radius) - cur_radius);
          by   = clamp_coord(ys[pick] + $urandom_range(0, 2 * cur_radius) - cur_radius);
        end else begin
          bx = pick_coord();
          by = pick_coord();
        end
        p.x     = FIELD_COORD_BITS'(bx);
        p.y     = FIELD_COORD_BITS'(by);
        p.first = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0);
        xs.insert(xs.size(), bx);
        ys.insert(ys.size(), by);
        send_point(p, burst ? 0 : $urandom_range(0, 8));
        sent++;
      end
    end
  endtask

  initial begin
    start       = 1'b0;
    in_i        = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_xy(0, 0, 1'b1);
    send_xy(4, 4, 1'b0);
    send_xy(5, 0, 1'b0);
    send_xy(COORD_MAX, COORD_MAX, 1'b0);
    send_xy(COORD_MAX - 4, COORD_MAX - 4, 1'b0);
    send_xy(COORD_MAX - 5, COORD_MAX, 1'b0);
    send_xy(12'hAAA, 12'h555, 1'b0);
    send_xy(12'h555, 12'hAAA, 1'b0);
    send_xy(COORD_MAX, 0, 1'b0);
    send_xy(0, COORD_MAX, 1'b0);
    send_xy(0, 0, 1'b1);
    send_xy(2, 3, 1'b0);

    write_radius(0);
    send_xy(100, 100, 1'b1);
    send_xy(100, 100, 1'b0);
    send_xy(0, 0, 1'b0);

    write_radius(255);
    send_xy(0, 0, 1'b1);
    send_xy(254, 254, 1'b0);
    send_xy(255, 0, 1'b0);
    send_xy(COORD_MAX, COORD_MAX, 1'b0);
    send_xy(COORD_MAX - 254, COORD_MAX - 254, 1'b0);

    write_radius(1);
    run_sets(200);
    write_radius(0);
    run_sets(200);
    write_radius(255);
    run_sets(200);
    write_radius($urandom_range(2, 16));
    run_sets(200);
    write_radius($urandom_range(0, 255));
    run_sets(200);
    write_radius(5);
    run_sets(200);

    wait_drain();
    repeat (TABLE_DEPTH + 8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
